// ===== design/bfp_pkg.sv =====
// bfp_pkg: shared constants and result type of the sync / length / xor frame parser
// no dependencies
`timescale 1ns / 1ps

package bfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hA0;
  localparam logic [7:0] SYNC_SECOND = 8'hA1;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_DATA = 3'd1,
    EV_GOOD = 3'd2,
    EV_ERRA = 3'd3,
    EV_ERRB = 3'd4
  } event_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [31:0] bad_frames;
  } res_t;

endpackage

// ===== design/bfp_if.sv =====
// bfp_in_if / bfp_out_if: valid-ready channels of the frame parser
// depends on nothing but plain logic types
`timescale 1ns / 1ps

interface bfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic [31:0] bad_frames;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output frame_id, output frame_length, output bad_frames, input ready);
  modport sink   (input valid, input event_res, input data_byte, input byte_index,
                  input frame_id, input frame_length, input bad_frames, output ready);
endinterface

// ===== design/bfp_in_stage.sv =====
// bfp_in_stage: input register of the frame parser
// depends on bfp_in_if
`timescale 1ns / 1ps

module bfp_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  bfp_in_if.sink      in_ch,
  input  logic        advance,
  output logic        vld,
  output logic [7:0]  rx_byte
);

  logic       vld_r;
  logic [7:0] byte_r;

  assign in_ch.ready = !vld_r || advance;
  assign vld         = vld_r;
  assign rx_byte     = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

endmodule

// ===== design/bfp_parser.sv =====
// bfp_parser: frame state, xor checksum and error count, one byte per step
// depends on bfp_pkg
`timescale 1ns / 1ps

module bfp_parser
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_SYNC2 = 3'd2,
    PH_LENLO = 3'd3,
    PH_LENHI = 3'd4,
    PH_BODY  = 3'd5,
    PH_CHKA  = 3'd6,
    PH_CHKB  = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [31:0] err_r, err_nxt;
  event_t      ev;
  logic [7:0]  dbyte;
  logic [15:0] idx;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    id_nxt    = id_r;
    err_nxt   = err_r;
    ev        = EV_NONE;
    dbyte     = 8'd0;
    idx       = 16'd0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC1;
      end
      PH_SYNC1: begin
        // anything but the second sync byte, a repeated first one too, goes back
        if (rx_byte == SYNC_SECOND) begin
          phase_nxt = PH_SYNC2;
          xor_nxt   = 8'd0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SYNC2: begin
        len_nxt   = {8'd0, rx_byte};
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt   = {rx_byte, len_r[7:0]};
        cnt_nxt   = 16'd0;
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        id_nxt    = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        xor_nxt = xor_r ^ rx_byte;
        ev      = EV_DATA;
        dbyte   = rx_byte;
        idx     = cnt_r;
        cnt_nxt = cnt_r + 16'd1;
        // zero length still takes one byte
        if (cnt_nxt >= len_r) phase_nxt = PH_CHKA;
      end
      PH_CHKA: begin
        if (rx_byte == xor_r) begin
          phase_nxt = PH_CHKB;
        end else begin
          ev        = EV_ERRA;
          err_nxt   = err_r + 32'd1;
          phase_nxt = PH_HUNT;
        end
      end
      PH_CHKB: begin
        if (rx_byte == xor_r) begin
          ev = EV_GOOD;
        end else begin
          ev      = EV_ERRB;
          err_nxt = err_r + 32'd1;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      xor_r   <= 8'd0;
      id_r    <= 8'd0;
      err_r   <= 32'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      id_r    <= id_nxt;
      err_r   <= err_nxt;
    end
  end

  assign res.event_res    = ev;
  assign res.data_byte    = dbyte;
  assign res.byte_index   = idx;
  assign res.frame_id     = id_nxt;
  assign res.frame_length = len_nxt;
  assign res.bad_frames   = err_nxt;

endmodule

// ===== design/bfp_out_stage.sv =====
// bfp_out_stage: result register of the frame parser
// depends on bfp_pkg and bfp_out_if
`timescale 1ns / 1ps

module bfp_out_stage
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       advance,
  bfp_out_if.source  out_ch
);

  logic vld_r;
  res_t res_r;

  // free when empty or when the held item leaves this cycle
  assign advance = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.data_byte    = res_r.data_byte;
  assign out_ch.byte_index   = res_r.byte_index;
  assign out_ch.frame_id     = res_r.frame_id;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.bad_frames   = res_r.bad_frames;

endmodule

// ===== design/binary_frame_parser_xor_check.sv =====
// channel   dir  handshake             payload
// in_ch     in   valid / ready         rx_byte[7:0]
// out_ch    out  valid / ready         event_res, data_byte, byte_index, frame_id,
//                                      frame_length, bad_frames
//
// one byte per cycle sustained while out_ch is ready; each item passes the input
// register and then the result register, with the parser's next-state logic between.
// every accepted byte gives exactly one result item.
// rst_n is synchronous: parser returns to sync hunting and all counts clear.
// a stalled result holds; the input register still takes one more byte behind it.
// depends on bfp_pkg, bfp_if, bfp_in_stage, bfp_parser, bfp_out_stage
`timescale 1ns / 1ps

module binary_frame_parser_xor_check
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bfp_in_if.sink     in_ch,
  bfp_out_if.source  out_ch
);

  logic       advance;
  logic       in_vld;
  logic [7:0] in_byte;
  logic       step;
  res_t       res;

  assign step = in_vld && advance;

  bfp_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .vld     (in_vld),
    .rx_byte (in_byte)
  );

  bfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte),
    .res     (res)
  );

  bfp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_vld),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // a payload byte's index stays inside its frame (zero length gives index 0)
  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res == EV_DATA |->
      (out_ch.byte_index < out_ch.frame_length) || (out_ch.byte_index == 16'd0))
    else $error("payload index beyond frame length");

  // only payload events carry data and index
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res != EV_DATA |->
      out_ch.data_byte == 8'd0 && out_ch.byte_index == 16'd0)
    else $error("non-payload item carries data");

  // with the result register empty the input side must take items
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while result register empty");

  // an error count change shows up only with a check error event
  a_count_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.event_res != EV_ERRA && res.event_res != EV_ERRB |=>
      $stable(u_parser.err_r))
    else $error("error count moved without a check error");
`endif

endmodule

// ===== test/tb_binary_frame_parser_xor_check.sv =====
// tb_binary_frame_parser_xor_check: self-checking bench of the sync / length / xor frame parser
// directed byte table then random frames and noise, checked against a byte-level parser model
// depends on bfp_pkg, bfp_if and binary_frame_parser_xor_check
`timescale 1ns / 1ps

module tb_binary_frame_parser_xor_check;
  import bfp_pkg::*;

  typedef enum logic [2:0] {
    P_HUNT, P_SYNC1, P_SYNC2, P_LENLO, P_LENHI, P_BODY, P_CHKA, P_CHKB
  } parse_phase_t;

  typedef struct {
    logic [7:0] rx;
    bit         pinned;
    res_t       want;
  } drill_row_t;

  logic clk;
  logic rst_n;

  bfp_in_if  in_ch ();
  bfp_out_if out_ch ();

  binary_frame_parser_xor_check i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser copy kept by the bench
  parse_phase_t ph;
  logic [15:0]  len_q;
  logic [15:0]  cnt_q;
  logic [7:0]   xor_q;
  logic [7:0]   id_q;
  logic [31:0]  err_q;

  res_t       pending_res[$];
  drill_row_t drill[$];

  int fail_count;
  int items_sent;
  int results_seen;
  int n_payload;
  int n_good;
  int n_bad;
  int drains;
  bit tx_calm;
  bit rx_calm;
  int rx_stall;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic res_t mk_res(input event_t ev, input logic [7:0] d, input logic [15:0] idx,
                                  input logic [7:0] id, input logic [15:0] len,
                                  input logic [31:0] bad);
    res_t r;
    r.event_res    = ev;
    r.data_byte    = d;
    r.byte_index   = idx;
    r.frame_id     = id;
    r.frame_length = len;
    r.bad_frames   = bad;
    return r;
  endfunction

  function automatic res_t parse_step(input logic [7:0] b);
    res_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (ph)
      P_HUNT: begin
        if (b == SYNC_FIRST) ph = P_SYNC1;
      end
      P_SYNC1: begin
        if (b == SYNC_SECOND) begin
          ph = P_SYNC2;
          xor_q = '0;
        end else begin
          ph = P_HUNT;
        end
      end
      P_SYNC2: begin
        len_q = {8'h00, b};
        ph = P_LENLO;
      end
      P_LENLO: begin
        len_q = {b, len_q[7:0]};
        cnt_q = '0;
        ph = P_LENHI;
      end
      P_LENHI: begin
        id_q = b;
        xor_q = xor_q ^ b;
        ph = P_BODY;
      end
      P_BODY: begin
        xor_q = xor_q ^ b;
        r.event_res = EV_DATA;
        r.data_byte = b;
        r.byte_index = cnt_q;
        cnt_q = cnt_q + 16'd1;
        // a zero length still ends after one payload byte
        if (cnt_q >= len_q) ph = P_CHKA;
      end
      P_CHKA: begin
        if (b == xor_q) begin
          ph = P_CHKB;
        end else begin
          r.event_res = EV_ERRA;
          err_q = err_q + 32'd1;
          ph = P_HUNT;
        end
      end
      default: begin
        if (b == xor_q) begin
          r.event_res = EV_GOOD;
        end else begin
          r.event_res = EV_ERRB;
          err_q = err_q + 32'd1;
        end
        ph = P_HUNT;
      end
    endcase
    r.frame_id     = id_q;
    r.frame_length = len_q;
    r.bad_frames   = err_q;
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random byte that never completes a sync pair by accident
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (ph == P_SYNC1 && b == SYNC_SECOND) b = 8'h00;
    return b;
  endfunction

  task automatic add_row(input logic [7:0] rx, input bit pinned, input res_t want);
    drill_row_t row;
    row.rx = rx;
    row.pinned = pinned;
    row.want = want;
    drill.push_back(row);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0, input res_t want = '0);
    int gap;
    res_t r;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    r = parse_step(b);
    if (pinned) r = want;
    pending_res.push_back(r);
    items_sent++;
  endtask

  task automatic send_frame(input int len, input int flaw);
    logic [7:0] x;
    logic [7:0] d;
    logic [7:0] k;
    int n;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    d = 8'($urandom_range(0, 255));
    send_byte(d);
    x = d;
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      x = x ^ d;
      send_byte(d);
    end
    k = 8'($urandom_range(1, 255));
    send_byte((flaw == 1) ? (x ^ k) : x);
    if (flaw != 1) send_byte((flaw == 2) ? (x ^ k) : x);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    drains++;
  endtask

  // result side: random stalls, check every accepted item
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
      if (rx_stall > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_calm) rx_stall <= pick_gap(1'b0);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = mk_res(event_t'(out_ch.event_res), out_ch.data_byte, out_ch.byte_index,
                     out_ch.frame_id, out_ch.frame_length, out_ch.bad_frames);
        results_seen++;
        case (got.event_res)
          EV_DATA: n_payload++;
          EV_GOOD: n_good++;
          EV_ERRA, EV_ERRB: n_bad++;
          default: ;
        endcase
        if (pending_res.size() == 0) begin
          $display("%0t: result item with nothing expected, event %0d", $time, got.event_res);
          fail_count++;
        end else begin
          want = pending_res.pop_front();
          if (got != want) begin
            fail_count++;
            if (got.event_res != want.event_res)
              $display("%0t: event_res expected %0d got %0d", $time,
                       want.event_res, got.event_res);
            if (got.data_byte != want.data_byte)
              $display("%0t: data_byte expected %h got %h", $time,
                       want.data_byte, got.data_byte);
            if (got.byte_index != want.byte_index)
              $display("%0t: byte_index expected %0d got %0d", $time,
                       want.byte_index, got.byte_index);
            if (got.frame_id != want.frame_id)
              $display("%0t: frame_id expected %h got %h", $time,
                       want.frame_id, got.frame_id);
            if (got.frame_length != want.frame_length)
              $display("%0t: frame_length expected %0d got %0d", $time,
                       want.frame_length, got.frame_length);
            if (got.bad_frames != want.bad_frames)
              $display("%0t: bad_frames expected %0d got %0d", $time,
                       want.bad_frames, got.bad_frames);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int sel;
    int len;
    int r;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    ph = P_HUNT;
    len_q = '0;
    cnt_q = '0;
    xor_q = '0;
    id_q = '0;
    err_q = '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    n_payload = 0;
    n_good = 0;
    n_bad = 0;
    drains = 0;
    tx_calm = 1'b0;

    // directed bytes: sync misses, zero length, both check errors, a good frame
    add_row(8'h00, 1'b1, mk_res(EV_NONE, 8'h00, 16'd0, 8'h00, 16'd0, 32'd0));
    add_row(SYNC_FIRST, 1'b1, mk_res(EV_NONE, 8'h00, 16'd0, 8'h00, 16'd0, 32'd0));
    add_row(SYNC_FIRST, 1'b0, '0);  // second 0xa0 drops back to hunting
    add_row(SYNC_SECOND, 1'b0, '0);
    add_row(SYNC_FIRST, 1'b0, '0);
    add_row(SYNC_SECOND, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h5A, 1'b0, '0);       // zero length still takes one payload byte
    add_row(8'h00, 1'b1, mk_res(EV_ERRA, 8'h00, 16'd0, 8'hFF, 16'd0, 32'd1));
    add_row(SYNC_FIRST, 1'b0, '0);
    add_row(SYNC_SECOND, 1'b0, '0);
    add_row(8'h02, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h80, 1'b0, '0);
    add_row(8'h7F, 1'b0, '0);
    add_row(8'h7F, 1'b1, mk_res(EV_GOOD, 8'h00, 16'd0, 8'h00, 16'd2, 32'd1));
    add_row(SYNC_FIRST, 1'b0, '0);
    add_row(SYNC_SECOND, 1'b0, '0);
    add_row(8'h01, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h3C, 1'b0, '0);
    add_row(8'hC3, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'h00, 1'b1, mk_res(EV_ERRB, 8'h00, 16'd0, 8'h3C, 16'd1, 32'd2));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill[i]) send_byte(drill[i].rx, drill[i].pinned, drill[i].want);
    drain_results();

    while (items_sent < 1430) begin
      if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        repeat ($urandom_range(1, 5)) send_byte(noise_byte());
      end else if (sel < 16) begin
        send_byte(SYNC_FIRST);
        send_byte(noise_byte());
      end else if (sel < 18) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 95) len = $urandom_range(1, 16);
        else len = $urandom_range(200, 300);
        r = $urandom_range(0, 9);
        send_frame(len, (r == 0) ? 1 : (r == 1) ? 2 : 0);
      end
      // get back to hunting, keeping any accidental length small
      while (ph != P_HUNT)
        send_byte((ph == P_SYNC2 || ph == P_LENLO) ? 8'h00 : noise_byte());
      if ((drains < 2 && items_sent > 700) || $urandom_range(0, 39) == 0) drain_results();
    end

    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bytes sent, %0d results checked, %0d payload items", items_sent,
             results_seen, n_payload);
    $display("%0d frames passed the checksum, %0d failed it", n_good, n_bad);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bfp_pkg.sv
design/bfp_if.sv
design/bfp_in_stage.sv
design/bfp_parser.sv
design/bfp_out_stage.sv
design/binary_frame_parser_xor_check.sv
test/tb_binary_frame_parser_xor_check.sv
